FILE: src/cdq_pkg.sv
// ============================================================================
// cdq_pkg - shared types, constants and functions for the Q-channel builder
// Holds the sector limits, reciprocal constants, BCD and CRC helpers.
// ============================================================================
package cdq_pkg;

    localparam int SECTOR_W = 19;
    localparam int STAGES   = 6;

    localparam logic [SECTOR_W-1:0] MAX_SECTOR_IN   = 19'd449849;
    localparam logic [SECTOR_W-1:0] MAX_MSF_SECTORS = 19'd449999;
    localparam logic [6:0]          BCD_MAX         = 7'd99;
    localparam logic [3:0]          ADR_POSITION    = 4'd1;

    localparam logic [3:0] DATA_NIBBLE_RESET  = 4'd4;
    localparam logic [3:0] AUDIO_NIBBLE_RESET = 4'd0;

    // register indexes of the configuration port
    localparam logic REG_DATA_CONTROL  = 1'b0;
    localparam logic REG_AUDIO_CONTROL = 1'b1;

    localparam logic [6:0]  FRAMES_PER_SEC = 7'd75;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;

    // floor(s / 75) = (s * DIV75_MUL) >> DIV75_SHIFT, exact for s < 2^22
    localparam logic [19:0] DIV75_MUL   = 20'd894785;
    localparam int          DIV75_SHIFT = 26;
    // floor(q / 60) = (q * DIV60_MUL) >> DIV60_SHIFT, exact for q < 23831
    localparam logic [14:0] DIV60_MUL   = 15'd17477;
    localparam int          DIV60_SHIFT = 20;
    // floor(v / 10) = (v * DIV10_MUL) >> DIV10_SHIFT, exact for v < 1029
    localparam logic [14:0] DIV10_MUL   = 15'd205;
    localparam int          DIV10_SHIFT = 11;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int          MSG_BITS = 80;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } msf_en_t;

    typedef struct packed {
        logic [7:0] control_address;
        logic [7:0] track_bcd;
        logic [7:0] index_bcd;
    } hdr_t;

    typedef logic [15:0][MSG_BITS-1:0] crc_mask_t;

    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(v) * DIV10_MUL;
        tens = p[DIV10_SHIFT +: 4];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

    // column of the CRC for every single message bit; evaluated at elaboration
    function automatic crc_mask_t crc_masks();
        crc_mask_t          m;
        logic [MSG_BITS-1:0] msg;
        logic [15:0]         crc;
        m = '0;
        for (int p = 0; p < MSG_BITS; p++)
        begin
            msg    = '0;
            msg[p] = 1'b1;
            crc    = 16'd0;
            for (int i = 0; i < MSG_BITS / 8; i++)
            begin
                crc = crc ^ {msg[MSG_BITS-1-8*i -: 8], 8'd0};
                for (int b = 0; b < 8; b++)
                begin
                    if (crc[15])
                        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
                    else
                        crc = {crc[14:0], 1'b0};
                end
            end
            for (int j = 0; j < 16; j++)
                m[j][p] = crc[j];
        end
        return m;
    endfunction

    localparam crc_mask_t CRC_MASK = crc_masks();

    // inverted CRC-16/CCITT, init zero, first byte in the top bits
    function automatic logic [15:0] q_check(input logic [MSG_BITS-1:0] msg);
        logic [15:0] crc;
        for (int j = 0; j < 16; j++)
            crc[j] = ^(msg & CRC_MASK[j]);
        return ~crc;
    endfunction

endpackage

FILE: src/cdq_msf.sv
// ============================================================================
// cdq_msf - sector count to BCD minutes, seconds and frames
// Three registered steps: divide by 75, split frames and divide by 60,
// split seconds and convert to BCD.
// ============================================================================
module cdq_msf
(
    input  logic                     clk,
    input  cdq_pkg::msf_en_t         en,
    input  logic [cdq_pkg::SECTOR_W-1:0] sector,
    output logic [7:0]               minute_bcd,
    output logic [6:0]               second_bcd,
    output logic [6:0]               frame_bcd
);
    import cdq_pkg::*;

    logic [SECTOR_W+19:0] prod75;
    logic [12:0]          q_a_next;
    logic [12:0]          q_a_reg;
    logic [SECTOR_W-1:0]  s_a_reg;

    logic [27:0]          prod60;
    logic [SECTOR_W-1:0]  frame_full;
    logic [6:0]           min_b_next;
    logic [6:0]           frame_b_next;
    logic [12:0]          q_b_reg;
    logic [6:0]           min_b_reg;
    logic [6:0]           frame_b_reg;

    logic [12:0]          sec_full;
    logic [7:0]           min_c_next;
    logic [7:0]           sec_c_next;
    logic [7:0]           frame_c_next;

    always_comb
    begin
        prod75   = 39'(sector) * 39'(DIV75_MUL);
        q_a_next = prod75[DIV75_SHIFT +: 13];
    end

    always_comb
    begin
        frame_full   = s_a_reg - 19'(q_a_reg) * 19'(FRAMES_PER_SEC);
        frame_b_next = frame_full[6:0];
        prod60       = 28'(q_a_reg) * 28'(DIV60_MUL);
        min_b_next   = prod60[DIV60_SHIFT +: 7];
    end

    always_comb
    begin
        sec_full     = q_b_reg - 13'(min_b_reg) * 13'(SECS_PER_MIN);
        min_c_next   = to_bcd(min_b_reg);
        sec_c_next   = to_bcd({1'b0, sec_full[5:0]});
        frame_c_next = to_bcd(frame_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            q_a_reg <= q_a_next;
            s_a_reg <= sector;
        end
        if (en.s3)
        begin
            q_b_reg     <= q_a_reg;
            min_b_reg   <= min_b_next;
            frame_b_reg <= frame_b_next;
        end
        if (en.s4)
        begin
            minute_bcd <= min_c_next;
            second_bcd <= sec_c_next[6:0];
            frame_bcd  <= frame_c_next[6:0];
        end
    end

endmodule

FILE: src/cd_q_channel_position_frame_builder.sv
// ============================================================================
// cd_q_channel_position_frame_builder - CD Q-channel mode-1 position frame
// Builds control/ADR, BCD track and index, relative and absolute MSF and the
// inverted CRC-16/CCITT check word from one position request word.
// ============================================================================
//
//  Channel | Handshake         | Payload
//  --------+-------------------+----------------------------------------------
//  in      | in_valid/in_stall | track, index, data flag, start and current
//  out     | out_valid/out_stall| control/ADR, track/index BCD, MSF, check word
//  cfg     | cfg_we            | cfg_index, cfg_data (control nibbles)
//
//  One word per cycle while out_stall is low; each accepted word passes
//  through six pipeline registers (input, range, two divider steps, BCD, CRC).
//  Reset clears all stage valid flags and loads the nibbles with 4 and 0.
//  Every stage fills while the one after it is stalled; in_stall rises only
//  once all six stages hold a word and out_stall is high.
//
module cd_q_channel_position_frame_builder
#(
    parameter int LEAD_IN_SECTORS = 150
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  track_number,
    input  logic [6:0]  index_number,
    input  logic        data_track,
    input  logic [18:0] track_start_sector,
    input  logic [18:0] current_sector,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  control_address,
    output logic [7:0]  track_bcd,
    output logic [7:0]  index_bcd,
    output logic [7:0]  rel_minute_bcd,
    output logic [6:0]  rel_second_bcd,
    output logic [6:0]  rel_frame_bcd,
    output logic        reserved_byte,
    output logic [7:0]  abs_minute_bcd,
    output logic [6:0]  abs_second_bcd,
    output logic [6:0]  abs_frame_bcd,
    output logic [15:0] check_word
);
    import cdq_pkg::*;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] feed;
    logic [STAGES-1:0] go;
    logic [STAGES-1:0] free;
    logic [STAGES-1:0] move;

    logic [3:0] data_nib_reg;
    logic [3:0] audio_nib_reg;

    logic [6:0]          trk0_reg;
    logic [6:0]          idx0_reg;
    logic                dat0_reg;
    logic [SECTOR_W-1:0] start0_reg;
    logic [SECTOR_W-1:0] cur0_reg;

    logic [6:0]          trk_sat;
    logic [6:0]          idx_sat;
    logic [SECTOR_W-1:0] start_sat;
    logic [SECTOR_W-1:0] cur_sat;
    logic [SECTOR_W:0]   abs_sum;
    logic [SECTOR_W-1:0] rel1_next;
    logic [SECTOR_W-1:0] abs1_next;
    hdr_t                hdr1_next;

    hdr_t                hdr1_reg;
    hdr_t                hdr2_reg;
    hdr_t                hdr3_reg;
    hdr_t                hdr4_reg;
    logic [SECTOR_W-1:0] rel1_reg;
    logic [SECTOR_W-1:0] abs1_reg;

    msf_en_t    msf_en;
    logic [7:0] rel_min4;
    logic [6:0] rel_sec4;
    logic [6:0] rel_frm4;
    logic [7:0] abs_min4;
    logic [6:0] abs_sec4;
    logic [6:0] abs_frm4;
    logic [MSG_BITS-1:0] msg;

    // stage handshake: a stage takes a word when empty or when it hands on
    assign feed = {v_reg[STAGES-2:0], in_valid};
    assign go   = {~out_stall, move[STAGES-1:1]};
    assign free = ~v_reg | go;
    assign move = feed & free;
    assign v_next = (v_reg & ~free) | move;

    assign in_stall  = ~free[0];
    assign out_valid = v_reg[STAGES-1];

    assign msf_en.s2 = move[2];
    assign msf_en.s3 = move[3];
    assign msf_en.s4 = move[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            data_nib_reg  <= DATA_NIBBLE_RESET;
            audio_nib_reg <= AUDIO_NIBBLE_RESET;
        end
        else
        begin
            v_reg <= v_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DATA_CONTROL:  data_nib_reg  <= cfg_data;
                    REG_AUDIO_CONTROL: audio_nib_reg <= cfg_data;
                    default:           data_nib_reg  <= data_nib_reg;
                endcase
            end
        end
    end

    // clamp, relative and absolute sector counts, header bytes
    always_comb
    begin
        trk_sat   = (trk0_reg > BCD_MAX) ? BCD_MAX : trk0_reg;
        idx_sat   = (idx0_reg > BCD_MAX) ? BCD_MAX : idx0_reg;
        start_sat = (start0_reg > MAX_SECTOR_IN) ? MAX_SECTOR_IN : start0_reg;
        cur_sat   = (cur0_reg > MAX_SECTOR_IN) ? MAX_SECTOR_IN : cur0_reg;

        if (cur_sat >= start_sat)
            rel1_next = cur_sat - start_sat;
        else if (idx_sat == 7'd0)
            rel1_next = start_sat - cur_sat;
        else
            rel1_next = '0;

        abs_sum   = {1'b0, cur_sat} + 20'(LEAD_IN_SECTORS);
        abs1_next = (abs_sum > {1'b0, MAX_MSF_SECTORS}) ? MAX_MSF_SECTORS
                                                        : abs_sum[SECTOR_W-1:0];

        hdr1_next.control_address = {(dat0_reg ? data_nib_reg : audio_nib_reg),
                                     ADR_POSITION};
        hdr1_next.track_bcd       = to_bcd(trk_sat);
        hdr1_next.index_bcd       = to_bcd(idx_sat);
    end

    always_ff @(posedge clk)
    begin
        if (move[0])
        begin
            trk0_reg   <= track_number;
            idx0_reg   <= index_number;
            dat0_reg   <= data_track;
            start0_reg <= track_start_sector;
            cur0_reg   <= current_sector;
        end
        if (move[1])
        begin
            hdr1_reg <= hdr1_next;
            rel1_reg <= rel1_next;
            abs1_reg <= abs1_next;
        end
        if (move[2])
            hdr2_reg <= hdr1_reg;
        if (move[3])
            hdr3_reg <= hdr2_reg;
        if (move[4])
            hdr4_reg <= hdr3_reg;
        if (move[5])
        begin
            control_address <= hdr4_reg.control_address;
            track_bcd       <= hdr4_reg.track_bcd;
            index_bcd       <= hdr4_reg.index_bcd;
            rel_minute_bcd  <= rel_min4;
            rel_second_bcd  <= rel_sec4;
            rel_frame_bcd   <= rel_frm4;
            abs_minute_bcd  <= abs_min4;
            abs_second_bcd  <= abs_sec4;
            abs_frame_bcd   <= abs_frm4;
            check_word      <= q_check(msg);
        end
    end

    cdq_msf u_rel_msf
    (
        .clk        (clk),
        .en         (msf_en),
        .sector     (rel1_reg),
        .minute_bcd (rel_min4),
        .second_bcd (rel_sec4),
        .frame_bcd  (rel_frm4)
    );

    cdq_msf u_abs_msf
    (
        .clk        (clk),
        .en         (msf_en),
        .sector     (abs1_reg),
        .minute_bcd (abs_min4),
        .second_bcd (abs_sec4),
        .frame_bcd  (abs_frm4)
    );

    assign msg = {hdr4_reg.control_address, hdr4_reg.track_bcd, hdr4_reg.index_bcd,
                  rel_min4, 1'b0, rel_sec4, 1'b0, rel_frm4, 8'd0,
                  abs_min4, 1'b0, abs_sec4, 1'b0, abs_frm4};

    assign reserved_byte = 1'b0;

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg))
        else $error("input stalled with an empty stage");

    a_adr_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (control_address[3:0] == ADR_POSITION))
        else $error("address mode lost");

    a_frame_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (abs_frame_bcd[3:0] <= 4'd9 && abs_frame_bcd[6:4] <= 3'd7
                       && rel_frame_bcd[3:0] <= 4'd9 && rel_frame_bcd[6:4] <= 3'd7))
        else $error("frame field not valid BCD");

    a_second_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (abs_second_bcd[6:4] <= 3'd5 && rel_second_bcd[6:4] <= 3'd5
                       && abs_second_bcd[3:0] <= 4'd9 && rel_second_bcd[3:0] <= 4'd9))
        else $error("second field not valid BCD");

    a_out_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[STAGES-2] && !out_stall) |=> out_valid)
        else $error("word lost before output register");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking bench for the CD Q-channel position frame builder
// Feeds position requests through a valid/stall driver, predicts every frame
// (control/ADR, BCD track and index, relative and absolute MSF, check word)
// from the current control nibbles, and compares each delivered frame field
// by field. Covers edge values, saturation, pregap countdown, random traffic
// with gaps and output back-pressure, and control nibbles of 0, F and random values.
// ============================================================================
module tb_top;

    localparam int LEAD_IN        = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam logic [15:0] CCITT_POLY = 16'h1021;

    typedef struct packed {
        logic [6:0]  track;
        logic [6:0]  index;
        logic        data;
        logic [18:0] start;
        logic [18:0] cur;
    } pos_req_t;

    typedef struct packed {
        logic [7:0]  control_address;
        logic [7:0]  track_bcd;
        logic [7:0]  index_bcd;
        logic [7:0]  rel_minute;
        logic [6:0]  rel_second;
        logic [6:0]  rel_frame;
        logic        reserved;
        logic [7:0]  abs_minute;
        logic [6:0]  abs_second;
        logic [6:0]  abs_frame;
        logic [15:0] check_word;
    } q_frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = cdq_pkg::REG_DATA_CONTROL;
    logic [3:0]  cfg_data = 4'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [6:0]  track_number = 7'd0;
    logic [6:0]  index_number = 7'd0;
    logic        data_track = 1'b0;
    logic [18:0] track_start_sector = 19'd0;
    logic [18:0] current_sector = 19'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  control_address;
    logic [7:0]  track_bcd;
    logic [7:0]  index_bcd;
    logic [7:0]  rel_minute_bcd;
    logic [6:0]  rel_second_bcd;
    logic [6:0]  rel_frame_bcd;
    logic        reserved_byte;
    logic [7:0]  abs_minute_bcd;
    logic [6:0]  abs_second_bcd;
    logic [6:0]  abs_frame_bcd;
    logic [15:0] check_word;

    logic [3:0]  data_nibble = cdq_pkg::DATA_NIBBLE_RESET;
    logic [3:0]  audio_nibble = cdq_pkg::AUDIO_NIBBLE_RESET;

    pos_req_t    requests_pending[$];
    q_frame_t    frames_due[$];
    pos_req_t    next_req;
    q_frame_t    frame_want;

    bit          snd_idle_en = 1'b1;
    bit          rcv_idle_en = 1'b1;
    int          send_gap = 0;
    int          stall_run = 0;
    int          hold_left = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    cd_q_channel_position_frame_builder #(
        .LEAD_IN_SECTORS(LEAD_IN)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .track_number       (track_number),
        .index_number       (index_number),
        .data_track         (data_track),
        .track_start_sector (track_start_sector),
        .current_sector     (current_sector),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .control_address    (control_address),
        .track_bcd          (track_bcd),
        .index_bcd          (index_bcd),
        .rel_minute_bcd     (rel_minute_bcd),
        .rel_second_bcd     (rel_second_bcd),
        .rel_frame_bcd      (rel_frame_bcd),
        .reserved_byte      (reserved_byte),
        .abs_minute_bcd     (abs_minute_bcd),
        .abs_second_bcd     (abs_second_bcd),
        .abs_frame_bcd      (abs_frame_bcd),
        .check_word         (check_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] bin_to_bcd(input int unsigned v);
        int unsigned c;
        c = (v > 99) ? 99 : v;
        return {4'(c / 10), 4'(c % 10)};
    endfunction

    function automatic void sectors_to_bcd_msf(input int unsigned s, output logic [7:0] mm,
                                               output logic [7:0] ss, output logic [7:0] ff);
        int unsigned c;
        c  = (s > cdq_pkg::MAX_MSF_SECTORS) ? int'(cdq_pkg::MAX_MSF_SECTORS) : s;
        ff = bin_to_bcd(c % 75);
        ss = bin_to_bcd((c / 75) % 60);
        mm = bin_to_bcd(c / 75 / 60);
    endfunction

    function automatic q_frame_t predict_frame(input pos_req_t r);
        q_frame_t    f;
        logic [7:0]  q [10];
        int unsigned idx;
        int unsigned start;
        int unsigned cur;
        int unsigned rel;
        logic [15:0] crc;
        idx   = (r.index > 99) ? 99 : r.index;
        start = (r.start > cdq_pkg::MAX_SECTOR_IN) ? int'(cdq_pkg::MAX_SECTOR_IN) : r.start;
        cur   = (r.cur > cdq_pkg::MAX_SECTOR_IN) ? int'(cdq_pkg::MAX_SECTOR_IN) : r.cur;
        q[0]  = {(r.data ? data_nibble : audio_nibble), cdq_pkg::ADR_POSITION};
        q[1]  = bin_to_bcd(r.track);
        q[2]  = bin_to_bcd(idx);
        // count down in the pregap, hold at zero before the start elsewhere
        if (cur >= start)
            rel = cur - start;
        else if (idx == 0)
            rel = start - cur;
        else
            rel = 0;
        sectors_to_bcd_msf(rel, q[3], q[4], q[5]);
        q[6] = 8'd0;
        sectors_to_bcd_msf(cur + LEAD_IN, q[7], q[8], q[9]);
        crc = 16'h0000;
        for (int i = 0; i < 10; i++)
        begin
            crc = crc ^ {q[i], 8'h00};
            for (int b = 0; b < 8; b++)
                crc = crc[15] ? ({crc[14:0], 1'b0} ^ CCITT_POLY) : {crc[14:0], 1'b0};
        end
        f.control_address = q[0];
        f.track_bcd       = q[1];
        f.index_bcd       = q[2];
        f.rel_minute      = q[3];
        f.rel_second      = q[4][6:0];
        f.rel_frame       = q[5][6:0];
        f.reserved        = 1'b0;
        f.abs_minute      = q[7];
        f.abs_second      = q[8][6:0];
        f.abs_frame       = q[9][6:0];
        f.check_word      = ~crc;
        return f;
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pos_req_t random_position();
        pos_req_t r;
        int       c;
        int       kind;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            // plausible disc position near the track start
            r.track = 7'($urandom_range(1, 99));
            c       = $urandom_range(0, 99);
            r.index = (c < 30) ? 7'd0 : (c < 85) ? 7'd1 : 7'($urandom_range(2, 99));
            r.data  = 1'($urandom_range(0, 1));
            r.start = 19'($urandom_range(0, 449849));
            c       = int'(r.start) + int'($urandom_range(0, 20000)) - 10000;
            if (c < 0)
                c = 0;
            if (c > 449849)
                c = 449849;
            r.cur = 19'(c);
        end
        else if (kind < 85)
        begin
            r.track = 7'($urandom_range(0, 99));
            r.index = 7'($urandom_range(0, 99));
            r.data  = 1'($urandom_range(0, 1));
            r.start = 19'($urandom_range(0, 449849));
            r.cur   = 19'($urandom_range(0, 449849));
        end
        else
            r = pos_req_t'(53'({$urandom, $urandom}));
        return r;
    endfunction

    task automatic push_req(input int t, input int i, input bit d, input int s, input int c);
        pos_req_t r;
        r.track = 7'(t);
        r.index = 7'(i);
        r.data  = d;
        r.start = 19'(s);
        r.cur   = 19'(c);
        requests_pending.push_back(r);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == cdq_pkg::REG_DATA_CONTROL)
            data_nibble = val;
        else
            audio_nibble = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (requests_pending.size() != 0 || in_valid || frames_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int count, input bit snd_idle, input bit rcv_idle,
                             input bit long_hold);
        @(negedge clk);
        snd_idle_en = snd_idle;
        rcv_idle_en = rcv_idle;
        for (int n = 0; n < count; n++)
            requests_pending.push_back(random_position());
        if (long_hold)
            holds_asked++;
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // driver: advance to the next request once the current word is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                frames_due.push_back(predict_frame({track_number, index_number, data_track,
                                                    track_start_sector, current_sector}));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (requests_pending.size() > 0)
                begin
                    next_req = requests_pending.pop_front();
                    track_number       <= next_req.track;
                    index_number       <= next_req.index;
                    data_track         <= next_req.data;
                    track_start_sector <= next_req.start;
                    current_sector     <= next_req.cur;
                    in_valid           <= 1'b1;
                    send_gap           <= snd_idle_en ? pause_len() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each delivered frame and drive back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("frame delivered with none outstanding");
                    mismatches++;
                end
                else
                begin
                    frame_want = frames_due.pop_front();
                    check_field("control_address", frame_want.control_address, control_address);
                    check_field("track_bcd", frame_want.track_bcd, track_bcd);
                    check_field("index_bcd", frame_want.index_bcd, index_bcd);
                    check_field("rel_minute_bcd", frame_want.rel_minute, rel_minute_bcd);
                    check_field("rel_second_bcd", frame_want.rel_second, rel_second_bcd);
                    check_field("rel_frame_bcd", frame_want.rel_frame, rel_frame_bcd);
                    check_field("reserved_byte", frame_want.reserved, reserved_byte);
                    check_field("abs_minute_bcd", frame_want.abs_minute, abs_minute_bcd);
                    check_field("abs_second_bcd", frame_want.abs_second, abs_second_bcd);
                    check_field("abs_frame_bcd", frame_want.abs_frame, abs_frame_bcd);
                    check_field("check_word", frame_want.check_word, check_word);
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (holds_done != holds_asked)
            begin
                out_stall  <= 1'b1;
                hold_left  <= LONG_HOLD - 1;
                holds_done <= holds_done + 1;
            end
            else if (!rcv_idle_en)
                out_stall <= 1'b0;
            else if (stall_run > 0)
                stall_run <= stall_run - 1;
            else if ($urandom_range(0, 99) < 35)
            begin
                out_stall <= 1'b1;
                stall_run <= pause_len();
            end
            else
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        push_req(0, 0, 0, 0, 0);
        push_req(99, 99, 1, 449849, 449849);
        push_req(100, 127, 1, 0, 449849);
        push_req(127, 100, 0, 524287, 524287);
        push_req(1, 0, 0, 449849, 0);
        push_req(1, 0, 1, 1000, 850);
        push_req(5, 1, 0, 1000, 850);
        push_req(7, 2, 1, 1000, 999);
        push_req(3, 1, 0, 1000, 1000);
        push_req(3, 1, 1, 1000, 1075);
        push_req(10, 0, 0, 0, 0);
        push_req(99, 1, 1, 449850, 449851);
        push_req(42, 63, 1, 19'h2AAAA, 19'h55555);
        push_req(85, 64, 0, 19'h55555, 19'h2AAAA);
        push_req(9, 9, 1, 4499, 4500);
        push_req(1, 1, 0, 74, 74 + 75 * 59);
        push_req(0, 1, 1, 0, 524287);
        push_req(64, 1, 0, 262144, 262143);
        push_req(31, 0, 1, 449849, 449848);
        push_req(50, 127, 0, 524287, 0);
        wait_drained();

        write_reg(cdq_pkg::REG_DATA_CONTROL, 4'hF);
        write_reg(cdq_pkg::REG_AUDIO_CONTROL, 4'h0);
        run_phase(120, 1'b1, 1'b1, 1'b0);

        write_reg(cdq_pkg::REG_DATA_CONTROL, 4'h0);
        write_reg(cdq_pkg::REG_AUDIO_CONTROL, 4'hF);
        run_phase(120, 1'b0, 1'b1, 1'b1);

        write_reg(cdq_pkg::REG_DATA_CONTROL, 4'($urandom));
        write_reg(cdq_pkg::REG_AUDIO_CONTROL, 4'($urandom));
        run_phase(150, 1'b0, 1'b0, 1'b0);

        write_reg(cdq_pkg::REG_DATA_CONTROL, 4'hF);
        write_reg(cdq_pkg::REG_AUDIO_CONTROL, 4'hF);
        run_phase(80, 1'b1, 1'b1, 1'b0);

        write_reg(cdq_pkg::REG_DATA_CONTROL, 4'h0);
        write_reg(cdq_pkg::REG_AUDIO_CONTROL, 4'h0);
        run_phase(80, 1'b1, 1'b1, 1'b0);

        repeat (cdq_pkg::STAGES + 4) @(posedge clk);
        if (frames_due.size() != 0)
        begin
            $error("%0d frames never delivered", frames_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
